// ===== rtl/i2cbm_pkg.sv =====
package i2cbm_pkg;

	// Command codes; codes 6 and 7 carry no meaning and are treated as no command
	typedef enum logic [2:0] {
		OP_NONE    = 3'd0,
		OP_START   = 3'd1,
		OP_STOP    = 3'd2,
		OP_WRITE   = 3'd3,
		OP_WAITACK = 3'd4,
		OP_READ    = 3'd5
	} op_t;

	// Step within a command sequence
	typedef enum logic [2:0] {
		PH_0 = 3'd0,
		PH_1 = 3'd1,
		PH_2 = 3'd2,
		PH_3 = 3'd3,
		PH_4 = 3'd4
	} phase_t;

	// Configuration register indexes
	localparam logic CFG_DELAY_TICKS = 1'b0;
	localparam logic CFG_ACK_TIMEOUT = 1'b1;

	localparam int DELAY_W = 16;
	localparam int TMO_W   = 8;

	localparam logic [DELAY_W-1:0] DELAY_TICKS_RST = 16'd1;
	localparam logic [TMO_W-1:0]   ACK_TIMEOUT_RST = 8'd250;

endpackage

// ===== rtl/i2c_bit_level_master.sv =====
// Channel  Direction  Handshake             Payload
// in       to block   in_valid / in_stall   op, tx_byte, send_ack, sda_in (one bus tick)
// out      from block out_valid / out_stall scl_level, sda_pull_low, busy_res, done_res,
//                                           rx_byte, nack
// cfg      to block   cfg_we                cfg_index, cfg_data
//
// One tick per clock cycle while in_stall is low: the bus state advances and the
// result register loads at the same edge that accepts a tick. The result register is
// the only stage; in_stall is high only while a result is held and out_stall is high.
// arst_n clears the bus state to idle with both lines released, and restores
// delay_ticks to 1 and ack_timeout to 250.
module i2c_bit_level_master (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [7:0]  tx_byte,
	input  logic        send_ack,
	input  logic        sda_in,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        scl_level,
	output logic        sda_pull_low,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  rx_byte,
	output logic        nack,

	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	// Configuration registers
	logic [i2cbm_pkg::DELAY_W-1:0] delay_ticks_q;
	logic [i2cbm_pkg::TMO_W-1:0]   ack_timeout_q;

	// Bus sequencer state
	i2cbm_pkg::op_t                cmd_q, cmd_d;
	i2cbm_pkg::phase_t             phase_q, phase_d;
	logic [2:0]                    bit_q, bit_d;
	logic [7:0]                    shift_q, shift_d;
	logic [i2cbm_pkg::DELAY_W-1:0] delay_q, delay_d;
	logic [i2cbm_pkg::TMO_W-1:0]   poll_q, poll_d;
	logic                          scl_q, scl_d;
	logic                          sda_q, sda_d;
	logic                          ack_q, ack_d;
	logic [7:0]                    rx_q, rx_d;
	logic                          nack_q, nack_d;

	// Result register
	logic                          out_valid_q;
	logic                          res_scl_q, res_sda_low_q, res_busy_q, res_done_q;
	logic [7:0]                    res_rx_q;
	logic                          res_nack_q;
	logic                          res_busy_d;

	logic                          accept;
	logic                          run;
	logic                          done;
	logic [i2cbm_pkg::DELAY_W-1:0] dly_load;
	logic                          op_valid;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;
	assign dly_load = (delay_ticks_q == '0) ? i2cbm_pkg::DELAY_W'(1) : delay_ticks_q;
	assign op_valid = (op >= 3'(i2cbm_pkg::OP_START)) && (op <= 3'(i2cbm_pkg::OP_READ));

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_ticks_q <= i2cbm_pkg::DELAY_TICKS_RST;
			ack_timeout_q <= i2cbm_pkg::ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				i2cbm_pkg::CFG_DELAY_TICKS: delay_ticks_q <= cfg_data;
				i2cbm_pkg::CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data[i2cbm_pkg::TMO_W-1:0];
				default: ;
			endcase
		end
	end

	// Next state: command load, delay countdown, then one sequence step
	always_comb begin
		cmd_d   = cmd_q;
		phase_d = phase_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		delay_d = delay_q;
		poll_d  = poll_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		ack_d   = ack_q;
		rx_d    = rx_q;
		nack_d  = nack_q;
		run     = 1'b0;
		done    = 1'b0;

		if (cmd_q == i2cbm_pkg::OP_NONE) begin
			if (op_valid) begin
				cmd_d   = i2cbm_pkg::op_t'(op);
				phase_d = i2cbm_pkg::PH_0;
				bit_d   = '0;
				poll_d  = '0;
				delay_d = '0;
				shift_d = (op == 3'(i2cbm_pkg::OP_WRITE)) ? tx_byte : 8'd0;
				ack_d   = send_ack;
				run     = 1'b1;
			end
		end else if (delay_q > i2cbm_pkg::DELAY_W'(1)) begin
			delay_d = delay_q - i2cbm_pkg::DELAY_W'(1);
		end else begin
			run = 1'b1;
		end

		if (run) begin
			unique case (cmd_d)
				i2cbm_pkg::OP_START: begin
					priority case (phase_d)
						i2cbm_pkg::PH_0: begin
							sda_d = 1'b1; scl_d = 1'b1;
							phase_d = i2cbm_pkg::PH_1; delay_d = dly_load;
						end
						i2cbm_pkg::PH_1: begin
							sda_d = 1'b0;
							phase_d = i2cbm_pkg::PH_2; delay_d = dly_load;
						end
						i2cbm_pkg::PH_2: begin
							scl_d = 1'b0;
							phase_d = i2cbm_pkg::PH_3; delay_d = dly_load;
						end
						default: done = 1'b1;
					endcase
				end
				i2cbm_pkg::OP_STOP: begin
					priority case (phase_d)
						i2cbm_pkg::PH_0: begin
							scl_d = 1'b0; sda_d = 1'b0;
							phase_d = i2cbm_pkg::PH_1; delay_d = dly_load;
						end
						i2cbm_pkg::PH_1: begin
							scl_d = 1'b1;
							phase_d = i2cbm_pkg::PH_2; delay_d = dly_load;
						end
						default: begin
							sda_d = 1'b1;
							done  = 1'b1;
						end
					endcase
				end
				i2cbm_pkg::OP_WRITE: begin
					priority case (phase_d)
						i2cbm_pkg::PH_0: begin
							sda_d = shift_d[7]; scl_d = 1'b1;
							phase_d = i2cbm_pkg::PH_1; delay_d = dly_load;
						end
						i2cbm_pkg::PH_1: begin
							scl_d   = 1'b0;
							shift_d = {shift_d[6:0], 1'b0};
							delay_d = dly_load;
							if (bit_d == 3'd7) begin
								// last bit: release SDA for the acknowledge
								sda_d   = 1'b1;
								phase_d = i2cbm_pkg::PH_2;
							end else begin
								bit_d   = bit_d + 3'd1;
								phase_d = i2cbm_pkg::PH_0;
							end
						end
						default: done = 1'b1;
					endcase
				end
				i2cbm_pkg::OP_WAITACK: begin
					priority case (phase_d)
						i2cbm_pkg::PH_0: begin
							sda_d = 1'b1;
							phase_d = i2cbm_pkg::PH_1; delay_d = dly_load;
						end
						i2cbm_pkg::PH_1: begin
							scl_d = 1'b1;
							phase_d = i2cbm_pkg::PH_2; delay_d = dly_load;
						end
						i2cbm_pkg::PH_2: begin
							// poll once per tick
							if (!sda_in) begin
								scl_d  = 1'b0;
								nack_d = 1'b0;
								done   = 1'b1;
							end else if (poll_d >= ack_timeout_q) begin
								// timed out: run a stop
								scl_d = 1'b0; sda_d = 1'b0;
								phase_d = i2cbm_pkg::PH_3; delay_d = dly_load;
							end else begin
								poll_d  = poll_d + i2cbm_pkg::TMO_W'(1);
								delay_d = '0;
							end
						end
						i2cbm_pkg::PH_3: begin
							scl_d = 1'b1;
							phase_d = i2cbm_pkg::PH_4; delay_d = dly_load;
						end
						default: begin
							sda_d  = 1'b1;
							nack_d = 1'b1;
							done   = 1'b1;
						end
					endcase
				end
				i2cbm_pkg::OP_READ: begin
					priority case (phase_d)
						i2cbm_pkg::PH_0: begin
							if (bit_d == 3'd0) sda_d = 1'b1;
							scl_d = 1'b0;
							phase_d = i2cbm_pkg::PH_1; delay_d = dly_load;
						end
						i2cbm_pkg::PH_1: begin
							scl_d   = 1'b1;
							shift_d = {shift_d[6:0], sda_in};
							delay_d = dly_load;
							if (bit_d == 3'd7) begin
								phase_d = i2cbm_pkg::PH_2;
							end else begin
								bit_d   = bit_d + 3'd1;
								phase_d = i2cbm_pkg::PH_0;
							end
						end
						i2cbm_pkg::PH_2: begin
							// ACK pulls SDA low, NACK releases it
							scl_d = 1'b0;
							sda_d = ~ack_d;
							phase_d = i2cbm_pkg::PH_3; delay_d = dly_load;
						end
						i2cbm_pkg::PH_3: begin
							scl_d = 1'b1;
							phase_d = i2cbm_pkg::PH_4; delay_d = dly_load;
						end
						default: begin
							scl_d = 1'b0;
							rx_d  = shift_d;
							done  = 1'b1;
						end
					endcase
				end
				default: done = 1'b1;
			endcase
		end

		if (done) begin
			cmd_d   = i2cbm_pkg::OP_NONE;
			phase_d = i2cbm_pkg::PH_0;
			delay_d = '0;
		end
	end

	// Result fields derived from the next state
	always_comb begin
		res_busy_d = (cmd_d != i2cbm_pkg::OP_NONE);
	end

	// Sequencer state advances once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= i2cbm_pkg::OP_NONE;
			phase_q <= i2cbm_pkg::PH_0;
			bit_q   <= '0;
			shift_q <= '0;
			delay_q <= '0;
			poll_q  <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ack_q   <= 1'b0;
			rx_q    <= '0;
			nack_q  <= 1'b0;
		end else if (accept) begin
			cmd_q   <= cmd_d;
			phase_q <= phase_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			delay_q <= delay_d;
			poll_q  <= poll_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			ack_q   <= ack_d;
			rx_q    <= rx_d;
			nack_q  <= nack_d;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_scl_q     <= scl_d;
			res_sda_low_q <= ~sda_d;
			res_busy_q    <= res_busy_d;
			res_done_q    <= done;
			res_rx_q      <= rx_d;
			res_nack_q    <= nack_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign scl_level    = res_scl_q;
	assign sda_pull_low = res_sda_low_q;
	assign busy_res     = res_busy_q;
	assign done_res     = res_done_q;
	assign rx_byte      = res_rx_q;
	assign nack         = res_nack_q;

endmodule
